@@ hw/rtl/utf8dec_pkg.sv @@
// Shared types and constants for the UTF-8 byte stream decoder.
package utf8dec_pkg;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_LEAD  = 2'd1;
   localparam logic [1:0] STATUS_BAD_CONT  = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

   localparam int CP_W  = 21;
   localparam int LEN_W = 3;

   typedef struct packed {
      logic [CP_W-1:0]  partial_value;
      logic [1:0]       pending_count;
      logic [LEN_W-1:0] open_length;
   } seq_state_type;

   typedef struct packed {
      logic             valid;
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] seq_length;
      logic [1:0]       status;
   } result_type;

endpackage

@@ hw/rtl/utf8dec_step.sv @@
// One decode step: next sequence state and optional result for a byte.
module utf8dec_step (
   input  logic [7:0]                 byte_in,
   input  logic                       end_of_data,
   input  utf8dec_pkg::seq_state_type state_cur,
   output utf8dec_pkg::seq_state_type state_nxt,
   output utf8dec_pkg::result_type    result
);

   logic [utf8dec_pkg::CP_W-1:0]  lead_bits;
   logic [utf8dec_pkg::LEN_W-1:0] lead_len;
   logic                          lead_ok;
   logic [utf8dec_pkg::CP_W-1:0]  shifted;
   logic [1:0]                    pend_dec;

   always_comb begin
      lead_ok   = 1'b1;
      lead_bits = '0;
      lead_len  = '0;
      if (byte_in inside {[8'hC2:8'hDF]}) begin
         lead_bits = {16'd0, byte_in[4:0]};
         lead_len  = 3'd2;
      end else if (byte_in inside {[8'hE0:8'hEF]}) begin
         lead_bits = {17'd0, byte_in[3:0]};
         lead_len  = 3'd3;
      end else if (byte_in inside {[8'hF0:8'hF4]}) begin
         lead_bits = {18'd0, byte_in[2:0]};
         lead_len  = 3'd4;
      end else begin
         lead_ok = 1'b0;
      end
   end

   assign shifted  = {state_cur.partial_value[utf8dec_pkg::CP_W-7:0], byte_in[5:0]};
   assign pend_dec = state_cur.pending_count - 2'd1;

   always_comb begin
      state_nxt = '0;
      result    = '0;
      if (state_cur.pending_count == 2'd0) begin
         if (byte_in[7] == 1'b0) begin
            result.valid      = 1'b1;
            result.code_point = {14'd0, byte_in[6:0]};
            result.seq_length = 3'd1;
            result.status     = utf8dec_pkg::STATUS_OK;
         end else if (!lead_ok) begin
            result.valid  = 1'b1;
            result.status = utf8dec_pkg::STATUS_BAD_LEAD;
         end else if (end_of_data) begin
            result.valid  = 1'b1;
            result.status = utf8dec_pkg::STATUS_TRUNCATED;
         end else begin
            state_nxt.partial_value = lead_bits;
            state_nxt.pending_count = lead_len[1:0] - 2'd1;
            state_nxt.open_length   = lead_len;
         end
      end else if (byte_in[7:6] != 2'b10) begin
         result.valid  = 1'b1;
         result.status = utf8dec_pkg::STATUS_BAD_CONT;
      end else if (pend_dec == 2'd0) begin
         result.valid      = 1'b1;
         result.code_point = shifted;
         result.seq_length = state_cur.open_length;
         result.status     = utf8dec_pkg::STATUS_OK;
      end else if (end_of_data) begin
         result.valid  = 1'b1;
         result.status = utf8dec_pkg::STATUS_TRUNCATED;
      end else begin
         state_nxt.partial_value = shifted;
         state_nxt.pending_count = pend_dec;
         state_nxt.open_length   = state_cur.open_length;
      end
   end

endmodule

@@ hw/rtl/utf8_byte_stream_decoder.sv @@
// Top level of the UTF-8 byte stream decoder.
// Takes one byte per cycle and returns one result per completed code point or
// error. Throughput is one byte per clock unless a result is held by rsp_tready
// back-pressure; a result's last byte sits in the input register, and the result
// register loads from it through the combinational decode step once it is free.
// Bytes that open or extend a sequence produce no result transfer.
module utf8_byte_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // end_of_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] seq_length
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   logic                       in_valid_ff, in_valid_in;
   logic [7:0]                 in_byte_ff;
   logic                       in_last_ff;
   utf8dec_pkg::seq_state_type state_ff, state_step;
   utf8dec_pkg::result_type    step_res;
   logic                       out_valid_ff, out_valid_in;
   logic [23:0]                out_data_ff;
   logic [1:0]                 out_user_ff;
   logic                       out_free;
   logic                       advance;
   logic                       req_take;

   utf8dec_step u_step (
      .byte_in     (in_byte_ff),
      .end_of_data (in_last_ff),
      .state_cur   (state_ff),
      .state_nxt   (state_step),
      .result      (step_res)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (out_free || !step_res.valid);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && step_res.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && step_res.valid) begin
         out_data_ff <= {step_res.seq_length, step_res.code_point};
         out_user_ff <= step_res.status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule
